FILE: rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, codes and helpers shared by the I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

   localparam int unsigned DELAY_BITS = 16;
   localparam int unsigned HP_BITS    = 16;

   localparam logic [HP_BITS-1:0] HALF_PERIOD_RESET = 16'd342;
   localparam logic [32:0] DELAY_MAX_WIDE = (33'd1 << DELAY_BITS) - 33'd1;

   localparam logic [3:0] BIT_COUNT   = 4'd8;
   localparam logic [3:0] FREE_PULSES = 4'd9;

   // command codes
   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_STOP  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;
   localparam logic [2:0] ACT_FREE  = 3'd5;

   // phase numbers
   localparam logic [2:0] PH_0 = 3'd0;
   localparam logic [2:0] PH_1 = 3'd1;
   localparam logic [2:0] PH_2 = 3'd2;
   localparam logic [2:0] PH_3 = 3'd3;
   localparam logic [2:0] PH_4 = 3'd4;

   typedef enum logic [5:0] {
      OP_IDLE  = 6'b000001,
      OP_START = 6'b000010,
      OP_STOP  = 6'b000100,
      OP_WRITE = 6'b001000,
      OP_READ  = 6'b010000,
      OP_FREE  = 6'b100000
   } op_type;

   // last field in the lowest bits
   typedef struct packed {
      logic       sda_in;
      logic       ack_to_send;
      logic [7:0] write_byte;
      logic [2:0] action;
   } req_type;

   typedef struct packed {
      logic       bus_clear;
      logic       ack_received;
      logic [7:0] read_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } rsp_type;

   localparam int unsigned REQ_BITS = $bits(req_type);
   localparam int unsigned RSP_BITS = $bits(rsp_type);

   // phase length: zero counts as one tick, saturate to the counter range
   function automatic logic [DELAY_BITS-1:0] delay_load(input logic [HP_BITS-1:0] hp);
      logic [32:0] wide;
      wide = {17'd0, hp};
      if (wide == 33'd0) begin
         wide = 33'd1;
      end
      if (wide > DELAY_MAX_WIDE) begin
         wide = DELAY_MAX_WIDE;
      end
      return wide[DELAY_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/i2cms_engine.sv
// ----------------------------------------------------------------------------
// i2cms_engine
// Bus sequencer state and the per-tick next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_engine (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             step,
   input  wire logic [i2cms_pkg::HP_BITS-1:0]    half_period,
   input  wire i2cms_pkg::req_type               req,
   output i2cms_pkg::rsp_type                    rsp
);

   i2cms_pkg::op_type                    op_ff, op_in;
   logic [2:0]                           phase_ff, phase_in;
   logic [3:0]                           bit_ff, bit_in;
   logic [7:0]                           shift_ff, shift_in;
   logic [7:0]                           tx_ff, tx_in;
   logic [i2cms_pkg::DELAY_BITS-1:0]     dly_ff, dly_in;
   logic                                 scl_ff, scl_in;
   logic                                 sda_ff, sda_in_lvl;
   logic                                 ack_ff, ack_in;
   logic                                 clr_ff, clr_in;
   logic                                 sack_ff, sack_in;
   logic                                 done;
   logic [i2cms_pkg::DELAY_BITS-1:0]     dly_load;
   logic [i2cms_pkg::DELAY_BITS-1:0]     dly_dec;
   logic [3:0]                           bit_inc;

   assign dly_load = i2cms_pkg::delay_load(half_period);
   assign dly_dec  = (dly_ff != '0) ? dly_ff - (i2cms_pkg::DELAY_BITS)'(1) : '0;
   assign bit_inc  = bit_ff + 4'd1;

   always_comb begin
      op_in      = op_ff;
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      tx_in      = tx_ff;
      dly_in     = dly_ff;
      scl_in     = scl_ff;
      sda_in_lvl = sda_ff;
      ack_in     = ack_ff;
      clr_in     = clr_ff;
      sack_in    = sack_ff;
      done       = 1'b0;

      if (op_ff == i2cms_pkg::OP_IDLE) begin
         bit_in = 4'd0;
         unique case (req.action)
            i2cms_pkg::ACT_START: begin
               op_in      = i2cms_pkg::OP_START;
               phase_in   = i2cms_pkg::PH_0;
               sda_in_lvl = 1'b0;
               dly_in     = dly_load;
            end
            i2cms_pkg::ACT_STOP: begin
               op_in      = i2cms_pkg::OP_STOP;
               phase_in   = i2cms_pkg::PH_0;
               scl_in     = 1'b0;
               sda_in_lvl = 1'b0;
               dly_in     = dly_load;
            end
            i2cms_pkg::ACT_WRITE: begin
               op_in      = i2cms_pkg::OP_WRITE;
               tx_in      = {req.write_byte[6:0], 1'b0};
               phase_in   = i2cms_pkg::PH_0;
               scl_in     = 1'b0;
               sda_in_lvl = req.write_byte[7];
               dly_in     = dly_load;
            end
            i2cms_pkg::ACT_READ: begin
               op_in      = i2cms_pkg::OP_READ;
               sack_in    = req.ack_to_send;
               phase_in   = i2cms_pkg::PH_0;
               scl_in     = 1'b0;
               sda_in_lvl = 1'b1;
               dly_in     = dly_load;
            end
            i2cms_pkg::ACT_FREE: begin
               if (req.sda_in) begin
                  clr_in   = 1'b1;
                  op_in    = i2cms_pkg::OP_IDLE;
                  phase_in = i2cms_pkg::PH_0;
                  dly_in   = '0;
                  done     = 1'b1;
               end else begin
                  op_in    = i2cms_pkg::OP_FREE;
                  phase_in = i2cms_pkg::PH_0;
                  scl_in   = 1'b0;
                  dly_in   = dly_load;
               end
            end
            default: begin
            end
         endcase
      end else begin
         dly_in = dly_dec;
         if (dly_dec == '0) begin
            // phase end
            unique case (op_ff)
               i2cms_pkg::OP_STOP: begin
                  if (phase_ff == i2cms_pkg::PH_0) begin
                     phase_in = i2cms_pkg::PH_1;
                     scl_in   = 1'b1;
                     dly_in   = dly_load;
                  end else if (phase_ff == i2cms_pkg::PH_1) begin
                     phase_in   = i2cms_pkg::PH_2;
                     scl_in     = 1'b1;
                     sda_in_lvl = 1'b1;
                     dly_in     = dly_load;
                  end else begin
                     op_in    = i2cms_pkg::OP_IDLE;
                     phase_in = i2cms_pkg::PH_0;
                     dly_in   = '0;
                     done     = 1'b1;
                  end
               end
               i2cms_pkg::OP_WRITE: begin
                  if (phase_ff == i2cms_pkg::PH_0) begin
                     phase_in = i2cms_pkg::PH_1;
                     scl_in   = 1'b1;
                     dly_in   = dly_load;
                  end else if (phase_ff == i2cms_pkg::PH_1) begin
                     bit_in = bit_inc;
                     if (bit_inc < i2cms_pkg::BIT_COUNT) begin
                        tx_in      = {tx_ff[6:0], 1'b0};
                        phase_in   = i2cms_pkg::PH_0;
                        scl_in     = 1'b0;
                        sda_in_lvl = tx_ff[7];
                     end else begin
                        phase_in   = i2cms_pkg::PH_2;
                        scl_in     = 1'b0;
                        sda_in_lvl = 1'b1;
                     end
                     dly_in = dly_load;
                  end else if (phase_ff == i2cms_pkg::PH_2) begin
                     phase_in = i2cms_pkg::PH_3;
                     scl_in   = 1'b1;
                     dly_in   = dly_load;
                  end else if (phase_ff == i2cms_pkg::PH_3) begin
                     ack_in   = ~req.sda_in;
                     phase_in = i2cms_pkg::PH_4;
                     dly_in   = dly_load;
                  end else begin
                     op_in    = i2cms_pkg::OP_IDLE;
                     phase_in = i2cms_pkg::PH_0;
                     dly_in   = '0;
                     done     = 1'b1;
                  end
               end
               i2cms_pkg::OP_READ: begin
                  if (phase_ff == i2cms_pkg::PH_0) begin
                     phase_in = i2cms_pkg::PH_1;
                     scl_in   = 1'b1;
                     dly_in   = dly_load;
                  end else if (phase_ff == i2cms_pkg::PH_1) begin
                     shift_in = {shift_ff[6:0], req.sda_in};
                     bit_in   = bit_inc;
                     scl_in   = 1'b0;
                     if (bit_inc < i2cms_pkg::BIT_COUNT) begin
                        phase_in   = i2cms_pkg::PH_0;
                        sda_in_lvl = 1'b1;
                     end else begin
                        phase_in   = i2cms_pkg::PH_2;
                        sda_in_lvl = ~sack_ff;
                     end
                     dly_in = dly_load;
                  end else if (phase_ff == i2cms_pkg::PH_2) begin
                     phase_in = i2cms_pkg::PH_3;
                     scl_in   = 1'b1;
                     dly_in   = dly_load;
                  end else begin
                     op_in    = i2cms_pkg::OP_IDLE;
                     phase_in = i2cms_pkg::PH_0;
                     dly_in   = '0;
                     done     = 1'b1;
                  end
               end
               i2cms_pkg::OP_FREE: begin
                  if (phase_ff == i2cms_pkg::PH_0) begin
                     phase_in = i2cms_pkg::PH_1;
                     scl_in   = 1'b1;
                     dly_in   = dly_load;
                  end else begin
                     bit_in = bit_inc;
                     if (req.sda_in || (bit_inc >= i2cms_pkg::FREE_PULSES)) begin
                        clr_in   = req.sda_in;
                        op_in    = i2cms_pkg::OP_IDLE;
                        phase_in = i2cms_pkg::PH_0;
                        dly_in   = '0;
                        done     = 1'b1;
                     end else begin
                        phase_in = i2cms_pkg::PH_0;
                        scl_in   = 1'b0;
                        dly_in   = dly_load;
                     end
                  end
               end
               default: begin
                  // start, and anything stray
                  op_in    = i2cms_pkg::OP_IDLE;
                  phase_in = i2cms_pkg::PH_0;
                  dly_in   = '0;
                  done     = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= i2cms_pkg::OP_IDLE;
         phase_ff <= i2cms_pkg::PH_0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         tx_ff    <= 8'd0;
         dly_ff   <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         clr_ff   <= 1'b0;
         sack_ff  <= 1'b0;
      end else if (step) begin
         op_ff    <= op_in;
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         tx_ff    <= tx_in;
         dly_ff   <= dly_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_lvl;
         ack_ff   <= ack_in;
         clr_ff   <= clr_in;
         sack_ff  <= sack_in;
      end
   end

   always_comb begin
      rsp.scl_out      = scl_in;
      rsp.sda_out      = sda_in_lvl;
      rsp.busy_res     = (op_in != i2cms_pkg::OP_IDLE);
      rsp.done_res     = done;
      rsp.read_byte    = shift_in;
      rsp.ack_received = ack_in;
      rsp.bus_clear    = clr_in;
   end

endmodule

`default_nettype wire

FILE: rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master: one tick item in, one line-drive and status item out.
// ----------------------------------------------------------------------------
//  channel  dir  width  contents
//  req      in   16     action, write_byte, ack_to_send, sda_in
//  rsp      out  16     scl_out, sda_out, busy_res, done_res, read_byte,
//                       ack_received, bus_clear
//  csr      in   16     half_period_cycles
//
//  one item per cycle while rsp is not stalled; a result follows its item through
//  the input register, then next-state logic into the result register
//  a stalled rsp holds the result register and backs up into req_tready
//  reset is synchronous; half_period_cycles returns to 342
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[2:0], write_byte[10:3], ack_to_send[11], sda_in[12], zero fill
   input  wire logic [15:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_byte[11:4],
   // ack_received[12], bus_clear[13], zero fill
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   logic                                  in_valid_ff;
   i2cms_pkg::req_type                    in_data_ff;
   logic                                  out_valid_ff;
   i2cms_pkg::rsp_type                    out_data_ff;
   logic [i2cms_pkg::HP_BITS-1:0]         hp_ff;
   logic                                  step;
   i2cms_pkg::rsp_type                    rsp_next;

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff <= i2cms_pkg::HALF_PERIOD_RESET;
      end else if (csr_we) begin
         hp_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= i2cms_pkg::req_type'(req_tdata[i2cms_pkg::REQ_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= rsp_next;
      end
   end

   i2cms_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .half_period (hp_ff),
      .req         (in_data_ff),
      .rsp         (rsp_next)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(16 - i2cms_pkg::RSP_BITS)'(0), out_data_ff};

endmodule

`default_nettype wire

FILE: rtl/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks on the I2C master bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // rsp_tdata bits
   localparam int unsigned SCL_BIT  = 0;
   localparam int unsigned BUSY_BIT = 2;
   localparam int unsigned DONE_BIT = 3;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[DONE_BIT] |-> !rsp_tdata[BUSY_BIT])
      else $error("done while still busy");

   a_idle_scl_high: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[BUSY_BIT] |-> rsp_tdata[SCL_BIT])
      else $error("scl held low while idle");

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_checker (.*);

`default_nettype wire
